// ===== rtl/core/nfs_pkg.sv =====
// Shared types and constants for the next-fit slot allocator.
// Used by nfs_ctrl, nfs_datapath and next_fit_slot_allocator; no dependencies.
`default_nettype none

package nfs_pkg;

    localparam int SLOT_IDX_W    = 6;
    localparam int CNT_W         = 7;
    localparam int STATUS_W      = 2;
    localparam int DEF_MAX_SLOTS = 64;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 7'd64;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                  action;
        logic [SLOT_IDX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] granted_slot;
        logic [STATUS_W-1:0]   status;
        logic [CNT_W-1:0]      avail_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic norm_sub;
        logic scan_init;
        logic scan_step;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_norm;
        logic last_issue;
    } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/nfs_ctrl.sv =====
// Sequencing state machine for the next-fit slot allocator.
// Depends on nfs_pkg for the command and status structs.
`default_nettype none

module nfs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output nfs_pkg::ctl_cmd_t      cmd,
    input  wire nfs_pkg::ctl_sts_t sts
);
    import nfs_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_NORM,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // bring the start point below the slot count, then scan
                if (sts.need_norm)
                begin
                    cmd.norm_sub = 1'b1;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
        done_next = (state_reg == S_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("accepted item did not raise busy");

endmodule

`default_nettype wire

// ===== rtl/core/nfs_datapath.sv =====
// Bitmap memory, scan pointer, free counter and result register of the
// next-fit slot allocator. Depends on nfs_pkg.
`default_nettype none

module nfs_datapath #(
    parameter int MAX_SLOTS = nfs_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [nfs_pkg::CNT_W-1:0]  cfg_data,
    input  wire nfs_pkg::req_t              req,
    input  wire nfs_pkg::ctl_cmd_t          cmd,
    output nfs_pkg::ctl_sts_t               sts,
    output nfs_pkg::rsp_t                   rsp
);
    import nfs_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);

    logic mem [MAX_SLOTS];

    logic [CNT_W-1:0]      slot_count_reg;
    logic [CNT_W-1:0]      hint_reg;
    logic                  action_reg;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0]      start_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic [CNT_W-1:0]      ptr_d_reg;
    logic [CNT_W-1:0]      issue_cnt_reg;
    logic                  rd_valid_reg;
    logic                  rd_data_reg;
    logic [CNT_W-1:0]      free_cnt_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      found_slot_reg;
    logic [AW-1:0]         clr_addr_reg;
    rsp_t                  rsp_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] n_last;
    logic             rel_ok;
    logic             grant;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             wr_data;

    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(slot_count_reg) > MAX_SLOTS)
        begin
            n_eff = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            n_eff = slot_count_reg;
        end
    end

    assign n_last = n_eff - CNT_W'(1);
    assign rel_ok = (action_reg == ACT_RELEASE) && ({1'b0, idx_reg} < n_eff);
    assign grant  = (action_reg == ACT_ACQUIRE) && found_reg;

    // the scan must cover slots 0..n-1 for every item, so reduce a start point that is not below n
    assign sts.clear_last = (clr_addr_reg == AW'(MAX_SLOTS - 1));
    assign sts.need_norm  = (start_reg >= n_eff);
    assign sts.last_issue = (issue_cnt_reg == n_last);

    // single write port: clearing pass, release, or grant
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = 1'b0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.scan_init && rel_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_reg);
        end
        else if (cmd.finish && grant)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(found_slot_reg);
            wr_data = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[AW'(ptr_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RESET;
            hint_reg       <= '0;
            clr_addr_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                slot_count_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            rd_valid_reg <= cmd.scan_step;
            if (cmd.finish)
            begin
                if (grant)
                begin
                    hint_reg <= (found_slot_reg == n_last) ? '0
                                                           : found_slot_reg + CNT_W'(1);
                    rsp_reg.granted_slot <= found_slot_reg[SLOT_IDX_W-1:0];
                    rsp_reg.status       <= ST_OK;
                    rsp_reg.avail_count  <= free_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    rsp_reg.granted_slot <= '0;
                    rsp_reg.avail_count  <= free_cnt_reg;
                    if (action_reg == ACT_ACQUIRE)
                    begin
                        rsp_reg.status <= ST_FULL;
                    end
                    else if (rel_ok)
                    begin
                        rsp_reg.status <= ST_OK;
                    end
                    else
                    begin
                        rsp_reg.status <= ST_RANGE;
                    end
                end
            end
        end
    end

    // item and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= req.action;
            idx_reg    <= req.slot_index;
            start_reg  <= hint_reg;
        end
        if (cmd.norm_sub)
        begin
            start_reg <= start_reg - n_eff;
        end
        if (cmd.scan_init)
        begin
            ptr_reg       <= start_reg;
            issue_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            found_reg     <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            ptr_d_reg     <= ptr_reg;
            ptr_reg       <= (ptr_reg == n_last) ? '0 : ptr_reg + CNT_W'(1);
            issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
        end
        // evaluate the bit read in the previous cycle
        if (rd_valid_reg && !rd_data_reg)
        begin
            free_cnt_reg <= free_cnt_reg + CNT_W'(1);
            if (!found_reg)
            begin
                found_reg      <= 1'b1;
                found_slot_reg <= ptr_d_reg;
            end
        end
    end

    assign rsp = rsp_reg;

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_reg.status == ST_FULL) |-> (rsp_reg.avail_count == '0))
        else $error("no free slot reported with nonzero free count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_reg.status != ST_OK) |-> (rsp_reg.granted_slot == '0))
        else $error("failed item carries a slot number");

endmodule

`default_nettype wire

// ===== rtl/core/next_fit_slot_allocator.sv =====
// Top level of the next-fit slot allocator: controller plus datapath.
// Depends on nfs_pkg, nfs_ctrl and nfs_datapath.
//
// Usage: raise start with req (action, slot_index); the item transfers at
// the clock edge where start is high and busy is low. An acquire scans the
// in-use bitmap from the next-search hint for the first free slot, a release
// clears the bit of an in-range slot. Exactly one result per item appears on
// rsp, marked by done high for a single cycle; the receiver cannot stall it.
// Timing: with n the effective slot count, done follows the one-bit-per-cycle
// bitmap memory scan over all n slots, which also counts free slots. When the
// slot count was lowered below the hint, n is first subtracted from the start
// point (a copy of the hint) until it is below n. A new item may be started in
// the cycle that done is high.
// Reset: the bitmap memory is cleared one entry per cycle, all MAX_SLOTS entries,
// with busy high; the hint resets to zero and slot_count to 64.
// Configuration: slot_count is written through cfg_valid/cfg_data; cfg_ready
// is low while busy, so a write never lands on an item in flight.
`default_nettype none

module next_fit_slot_allocator #(
    parameter int MAX_SLOTS = nfs_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire nfs_pkg::req_t             req,
    output logic                           busy,
    output logic                           done,
    output nfs_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [nfs_pkg::CNT_W-1:0] cfg_data
);
    import nfs_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = !busy;

    nfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    nfs_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .req      (req),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
